@@ hw/rtl/nbge_pkg.sv @@
// shared constants, state type and saturation helpers for the n-body euler step block
`timescale 1ns / 1ps
`default_nettype none

package nbge_pkg;

    localparam int MAX_BODIES    = 64;
    localparam int IDX_W         = $clog2(MAX_BODIES);
    localparam int CNT_W         = $clog2(MAX_BODIES + 1);
    localparam int SOFTENING_LSB = 66;

    // body entry: mass, pos x, pos y, vel x, vel y
    localparam int BODY_W  = 160;
    localparam int FORCE_W = 48;
    localparam int FACC_W  = 2 * FORCE_W;

    // serial divider sizes
    localparam int DIV_W     = 96;
    localparam int DEN_W     = 34;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic [31:0] GRAV_RESET = 32'h0001_0000;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_STEP  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_ROW_RD,
        ST_ROW_LD,
        ST_PAIR_RD,
        ST_PAIR_LD,
        ST_DIFF,
        ST_SQX,
        ST_SQY,
        ST_SQRT,
        ST_MM,
        ST_GP_LO,
        ST_GP_HI,
        ST_Q_GO,
        ST_Q_WT,
        ST_F_GO,
        ST_F_WT,
        ST_FX_LO,
        ST_FX_HI,
        ST_FX_GO,
        ST_FX_WT,
        ST_FY_LO,
        ST_FY_HI,
        ST_FY_GO,
        ST_FY_WT,
        ST_ACC,
        ST_ROW_END,
        ST_UPD_RD,
        ST_UPD_LD,
        ST_AX_GO,
        ST_AX_WT,
        ST_AY_GO,
        ST_AY_WT,
        ST_VMUL,
        ST_VADD,
        ST_XMUL,
        ST_XADD
    } state_t;

    // clamp a 49-bit sum to the 48-bit signed range
    function automatic logic [47:0] sat48(input logic [48:0] v);
        logic [47:0] r;
        if (v[48] != v[47]) begin
            r = v[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
        end
        else begin
            r = v[47:0];
        end
        return r;
    endfunction

    // clamp a 50-bit sum to the 32-bit signed range
    function automatic logic [31:0] sat32(input logic [49:0] v);
        logic [31:0] r;
        if (v[49:31] != {19{v[49]}}) begin
            r = v[49] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
        end
        else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/nbody_gravity_euler_step.sv @@
// top level: body store, pairwise force sequencer and euler update
// add, clear and failed commands answer in the cycle after the transaction; busy stays low.
// a step runs each body pair through a square root and four divisions, then each body
// through two divisions; all divisions share the 96-bit serial divider.
// one item at a time, results cannot stall.
// reset: no bodies, gravity 1.0; stored bodies are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module nbody_gravity_euler_step (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  cmd,
    input  wire logic [31:0] body_mass,
    input  wire logic [31:0] init_pos_x,
    input  wire logic [31:0] init_pos_y,
    input  wire logic [31:0] init_vel_x,
    input  wire logic [31:0] init_vel_y,
    input  wire logic [15:0] step_dt,
    output logic             result_valid,
    output logic [1:0]       status,
    output logic [5:0]       body_index,
    output logic [31:0]      new_pos_x,
    output logic [31:0]      new_pos_y,
    output logic [31:0]      new_vel_x,
    output logic [31:0]      new_vel_y,
    output logic             last
);

    import nbge_pkg::*;

    // control state
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [4:0]       sq_cnt_reg, sq_cnt_next;
    logic [31:0]      grav_reg;

    // result registers
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_status_reg, out_status_next;
    logic [5:0]  out_idx_reg, out_idx_next;
    logic [31:0] out_px_reg, out_px_next;
    logic [31:0] out_py_reg, out_py_next;
    logic [31:0] out_vx_reg, out_vx_next;
    logic [31:0] out_vy_reg, out_vy_next;
    logic        out_last_reg, out_last_next;

    // datapath registers
    logic [15:0]        dt_reg;
    logic [31:0]        mi_reg, xi_reg, yi_reg, vx_reg, vy_reg;
    logic [31:0]        mj_reg, xj_reg, yj_reg;
    logic [FORCE_W-1:0] acc_x_reg, acc_y_reg, fjx_reg, fjy_reg;
    logic [32:0]        ax_reg, ay_reg;
    logic               sx_reg, sy_reg;
    logic [63:0]        sqx_reg, sqn_reg, sqr_reg, sqb_reg;
    logic [DEN_W-1:0]   d_reg;
    logic [63:0]        p_reg, gpl_reg, gph_reg;
    logic [62:0]        q_reg;
    logic [46:0]        f_reg, fx_reg, fy_reg;
    logic [64:0]        pl_reg;
    logic [47:0]        ph_reg;
    logic [47:0]        amx_reg, amy_reg, tx_reg, ty_reg;

    // memories
    logic               body_we, force_we;
    logic [IDX_W-1:0]   body_waddr, force_waddr, rd_addr;
    logic [BODY_W-1:0]  body_wdata, body_rdata;
    logic [FACC_W-1:0]  force_wdata, force_rdata;

    // divider
    logic               div_start, div_done;
    logic [DIV_W-1:0]   div_dividend, div_quot;
    logic [DEN_W-1:0]   div_divisor;

    logic accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    nbge_ram #(
        .WIDTH (BODY_W),
        .DEPTH (MAX_BODIES)
    ) u_body_ram (
        .clk   (clk),
        .we    (body_we),
        .waddr (body_waddr),
        .wdata (body_wdata),
        .raddr (rd_addr),
        .rdata (body_rdata)
    );

    nbge_ram #(
        .WIDTH (FACC_W),
        .DEPTH (MAX_BODIES)
    ) u_force_ram (
        .clk   (clk),
        .we    (force_we),
        .waddr (force_waddr),
        .wdata (force_wdata),
        .raddr (rd_addr),
        .rdata (force_rdata)
    );

    nbge_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // combinational products, registered by the states that use them
    logic [65:0] sqx_prod, sqy_prod;
    logic [63:0] mm_prod, gpl_prod, gph_prod;
    logic [32:0] f_op;
    logic [64:0] pl_prod;
    logic [47:0] ph_prod;
    logic [63:0] amx_prod, amy_prod;
    logic [31:0] vx_mag, vy_mag;
    logic [47:0] vpx_prod, vpy_prod;

    assign sqx_prod = ax_reg * ax_reg;
    assign sqy_prod = ay_reg * ay_reg;
    assign mm_prod  = mi_reg * mj_reg;
    assign gpl_prod = grav_reg * p_reg[31:0];
    assign gph_prod = grav_reg * p_reg[63:32];
    assign f_op     = (state_reg == ST_FY_LO || state_reg == ST_FY_HI) ? ay_reg : ax_reg;
    assign pl_prod  = f_reg[31:0] * f_op;
    assign ph_prod  = f_reg[46:32] * f_op;
    assign amx_prod = amx_reg * dt_reg;
    assign amy_prod = amy_reg * dt_reg;
    assign vx_mag   = vx_reg[31] ? (32'd0 - vx_reg) : vx_reg;
    assign vy_mag   = vy_reg[31] ? (32'd0 - vy_reg) : vy_reg;
    assign vpx_prod = vx_mag * dt_reg;
    assign vpy_prod = vy_mag * dt_reg;

    // square root step
    logic [63:0] sq_t;
    assign sq_t = sqr_reg + sqb_reg;

    // signed pair force and saturating accumulation
    logic [FORCE_W-1:0] sfx, sfy, acc_x_new, acc_y_new, fjx_new, fjy_new;
    assign sfx       = sx_reg ? (FORCE_W'(0) - {1'b0, fx_reg}) : {1'b0, fx_reg};
    assign sfy       = sy_reg ? (FORCE_W'(0) - {1'b0, fy_reg}) : {1'b0, fy_reg};
    assign acc_x_new = sat48({acc_x_reg[47], acc_x_reg} + {sfx[47], sfx});
    assign acc_y_new = sat48({acc_y_reg[47], acc_y_reg} + {sfy[47], sfy});
    assign fjx_new   = sat48({fjx_reg[47], fjx_reg} - {sfx[47], sfx});
    assign fjy_new   = sat48({fjy_reg[47], fjy_reg} - {sfy[47], sfy});

    // force magnitudes and mass divisor for the body update
    logic [47:0]      fmag_x, fmag_y;
    logic [DEN_W-1:0] mass_den;
    assign fmag_x   = acc_x_reg[47] ? (48'd0 - acc_x_reg) : acc_x_reg;
    assign fmag_y   = acc_y_reg[47] ? (48'd0 - acc_y_reg) : acc_y_reg;
    assign mass_den = (mi_reg == 32'd0) ? DEN_W'(1) : {2'b0, mi_reg};

    // velocity and position sums
    logic [49:0] dvx, dvy, dpx, dpy;
    logic [31:0] vx_new, vy_new, px_new, py_new;
    assign dvx    = acc_x_reg[47] ? (50'd0 - {2'b0, tx_reg}) : {2'b0, tx_reg};
    assign dvy    = acc_y_reg[47] ? (50'd0 - {2'b0, ty_reg}) : {2'b0, ty_reg};
    assign vx_new = sat32({{18{vx_reg[31]}}, vx_reg} + dvx);
    assign vy_new = sat32({{18{vy_reg[31]}}, vy_reg} + dvy);
    assign dpx    = vx_reg[31] ? (50'd0 - {2'b0, tx_reg}) : {2'b0, tx_reg};
    assign dpy    = vy_reg[31] ? (50'd0 - {2'b0, ty_reg}) : {2'b0, ty_reg};
    assign px_new = sat32({{18{xi_reg[31]}}, xi_reg} + dpx);
    assign py_new = sat32({{18{yi_reg[31]}}, yi_reg} + dpy);

    // sequencer: next state, memory access, divider launch, results
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        sq_cnt_next     = sq_cnt_reg;
        body_we         = 1'b0;
        body_waddr      = count_reg[IDX_W-1:0];
        body_wdata      = {body_mass, init_pos_x, init_pos_y, init_vel_x, init_vel_y};
        force_we        = 1'b0;
        force_waddr     = i_reg;
        force_wdata     = {acc_x_reg, acc_y_reg};
        rd_addr         = i_reg;
        div_start       = 1'b0;
        div_dividend    = '0;
        div_divisor     = d_reg;
        out_valid_next  = 1'b0;
        out_status_next = out_status_reg;
        out_idx_next    = out_idx_reg;
        out_px_next     = out_px_reg;
        out_py_next     = out_py_reg;
        out_vx_next     = out_vx_reg;
        out_vy_next     = out_vy_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd)
                        CMD_ADD:
                        begin
                            out_valid_next = 1'b1;
                            out_last_next  = 1'b1;
                            if (count_reg >= CNT_W'(MAX_BODIES))
                            begin
                                out_status_next = STAT_FULL;
                                out_idx_next    = '0;
                                out_px_next     = '0;
                                out_py_next     = '0;
                                out_vx_next     = '0;
                                out_vy_next     = '0;
                            end
                            else
                            begin
                                body_we         = 1'b1;
                                count_next      = count_reg + 1'b1;
                                out_status_next = STAT_OK;
                                out_idx_next    = 6'(count_reg);
                                out_px_next     = init_pos_x;
                                out_py_next     = init_pos_y;
                                out_vx_next     = init_vel_x;
                                out_vy_next     = init_vel_y;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next      = '0;
                            out_valid_next  = 1'b1;
                            out_last_next   = 1'b1;
                            out_status_next = STAT_OK;
                            out_idx_next    = '0;
                            out_px_next     = '0;
                            out_py_next     = '0;
                            out_vx_next     = '0;
                            out_vy_next     = '0;
                        end
                        CMD_STEP:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next  = 1'b1;
                                out_last_next   = 1'b1;
                                out_status_next = STAT_EMPTY;
                                out_idx_next    = '0;
                                out_px_next     = '0;
                                out_py_next     = '0;
                                out_vx_next     = '0;
                                out_vy_next     = '0;
                            end
                            else
                            begin
                                i_next     = '0;
                                state_next = (count_reg == CNT_W'(1)) ? ST_UPD_RD : ST_ROW_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_ROW_RD:
            begin
                state_next = ST_ROW_LD;
            end
            ST_ROW_LD:
            begin
                j_next     = CNT_W'(i_reg) + 1'b1;
                state_next = ST_PAIR_RD;
            end
            ST_PAIR_RD:
            begin
                rd_addr    = j_reg[IDX_W-1:0];
                state_next = ST_PAIR_LD;
            end
            ST_PAIR_LD: state_next = ST_DIFF;
            ST_DIFF:    state_next = ST_SQX;
            ST_SQX:     state_next = ST_SQY;
            ST_SQY:
            begin
                sq_cnt_next = '0;
                state_next  = ST_SQRT;
            end
            ST_SQRT:
            begin
                sq_cnt_next = sq_cnt_reg + 1'b1;
                if (sq_cnt_reg == 5'd31)
                begin
                    state_next = ST_MM;
                end
            end
            ST_MM:    state_next = ST_GP_LO;
            ST_GP_LO: state_next = ST_GP_HI;
            ST_GP_HI: state_next = ST_Q_GO;
            ST_Q_GO:
            begin
                div_start    = 1'b1;
                div_dividend = {gph_reg, 32'b0} + {32'b0, gpl_reg};
                state_next   = ST_Q_WT;
            end
            ST_Q_WT:
            begin
                if (div_done)
                begin
                    state_next = ST_F_GO;
                end
            end
            ST_F_GO:
            begin
                div_start    = 1'b1;
                div_dividend = {1'b0, q_reg, 32'b0};
                state_next   = ST_F_WT;
            end
            ST_F_WT:
            begin
                if (div_done)
                begin
                    state_next = ST_FX_LO;
                end
            end
            ST_FX_LO: state_next = ST_FX_HI;
            ST_FX_HI: state_next = ST_FX_GO;
            ST_FX_GO:
            begin
                div_start    = 1'b1;
                div_dividend = {16'b0, {ph_reg, 32'b0} + {15'b0, pl_reg}};
                state_next   = ST_FX_WT;
            end
            ST_FX_WT:
            begin
                if (div_done)
                begin
                    state_next = ST_FY_LO;
                end
            end
            ST_FY_LO: state_next = ST_FY_HI;
            ST_FY_HI: state_next = ST_FY_GO;
            ST_FY_GO:
            begin
                div_start    = 1'b1;
                div_dividend = {16'b0, {ph_reg, 32'b0} + {15'b0, pl_reg}};
                state_next   = ST_FY_WT;
            end
            ST_FY_WT:
            begin
                if (div_done)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                force_we    = 1'b1;
                force_waddr = j_reg[IDX_W-1:0];
                force_wdata = {fjx_new, fjy_new};
                j_next      = j_reg + 1'b1;
                state_next  = (j_reg + 1'b1 == count_reg) ? ST_ROW_END : ST_PAIR_RD;
            end
            ST_ROW_END:
            begin
                force_we = 1'b1;
                if (CNT_W'(i_reg) + CNT_W'(2) == count_reg)
                begin
                    i_next     = '0;
                    state_next = ST_UPD_RD;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_ROW_RD;
                end
            end
            ST_UPD_RD: state_next = ST_UPD_LD;
            ST_UPD_LD: state_next = ST_AX_GO;
            ST_AX_GO:
            begin
                div_start    = 1'b1;
                div_dividend = {48'b0, fmag_x};
                div_divisor  = mass_den;
                state_next   = ST_AX_WT;
            end
            ST_AX_WT:
            begin
                if (div_done)
                begin
                    state_next = ST_AY_GO;
                end
            end
            ST_AY_GO:
            begin
                div_start    = 1'b1;
                div_dividend = {48'b0, fmag_y};
                div_divisor  = mass_den;
                state_next   = ST_AY_WT;
            end
            ST_AY_WT:
            begin
                if (div_done)
                begin
                    state_next = ST_VMUL;
                end
            end
            ST_VMUL: state_next = ST_VADD;
            ST_VADD: state_next = ST_XMUL;
            ST_XMUL: state_next = ST_XADD;
            ST_XADD:
            begin
                body_we         = 1'b1;
                body_waddr      = i_reg;
                body_wdata      = {mi_reg, px_new, py_new, vx_reg, vy_reg};
                out_valid_next  = 1'b1;
                out_status_next = STAT_OK;
                out_idx_next    = 6'(i_reg);
                out_px_next     = px_new;
                out_py_next     = py_new;
                out_vx_next     = vx_reg;
                out_vy_next     = vy_reg;
                if (CNT_W'(i_reg) + 1'b1 == count_reg)
                begin
                    out_last_next = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    out_last_next = 1'b0;
                    i_next        = i_reg + 1'b1;
                    state_next    = ST_UPD_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control and result strobe registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            sq_cnt_reg    <= '0;
            grav_reg      <= GRAV_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            sq_cnt_reg    <= sq_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                grav_reg <= cfg_wdata;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_idx_reg    <= out_idx_next;
        out_px_reg     <= out_px_next;
        out_py_reg     <= out_py_next;
        out_vx_reg     <= out_vx_next;
        out_vy_reg     <= out_vy_next;
        out_last_reg   <= out_last_next;
    end

    // datapath registers, loaded per sequencer state
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dt_reg <= step_dt;
        end
        unique case (state_reg)
            ST_ROW_LD:
            begin
                mi_reg    <= body_rdata[159:128];
                xi_reg    <= body_rdata[127:96];
                yi_reg    <= body_rdata[95:64];
                acc_x_reg <= (i_reg == '0) ? '0 : force_rdata[95:48];
                acc_y_reg <= (i_reg == '0) ? '0 : force_rdata[47:0];
            end
            ST_PAIR_LD:
            begin
                mj_reg  <= body_rdata[159:128];
                xj_reg  <= body_rdata[127:96];
                yj_reg  <= body_rdata[95:64];
                fjx_reg <= (i_reg == '0) ? '0 : force_rdata[95:48];
                fjy_reg <= (i_reg == '0) ? '0 : force_rdata[47:0];
            end
            ST_DIFF:
            begin : diff_blk
                logic [32:0] dx, dy;
                dx = {xj_reg[31], xj_reg} - {xi_reg[31], xi_reg};
                dy = {yj_reg[31], yj_reg} - {yi_reg[31], yi_reg};
                ax_reg <= dx[32] ? (33'd0 - dx) : dx;
                ay_reg <= dy[32] ? (33'd0 - dy) : dy;
                sx_reg <= dx[32];
                sy_reg <= dy[32];
            end
            ST_SQX:
            begin
                sqx_reg <= sqx_prod[65:2];
            end
            ST_SQY:
            begin
                sqn_reg <= sqx_reg + sqy_prod[65:2];
                sqr_reg <= '0;
                sqb_reg <= 64'h4000_0000_0000_0000;
            end
            ST_SQRT:
            begin
                if (sqn_reg >= sq_t)
                begin
                    sqn_reg <= sqn_reg - sq_t;
                    sqr_reg <= (sqr_reg >> 1) + sqb_reg;
                end
                else
                begin
                    sqr_reg <= sqr_reg >> 1;
                end
                sqb_reg <= sqb_reg >> 2;
            end
            ST_MM:
            begin
                d_reg <= {sqr_reg[32:0], 1'b0} + DEN_W'(SOFTENING_LSB);
                p_reg <= mm_prod;
            end
            ST_GP_LO: gpl_reg <= gpl_prod;
            ST_GP_HI: gph_reg <= gph_prod;
            ST_Q_WT:
            begin
                if (div_done)
                begin
                    q_reg <= (div_quot[95:63] != '0) ? {63{1'b1}} : div_quot[62:0];
                end
            end
            ST_F_WT:
            begin
                if (div_done)
                begin
                    f_reg <= (div_quot[95:47] != '0) ? {47{1'b1}} : div_quot[46:0];
                end
            end
            ST_FX_LO, ST_FY_LO: pl_reg <= pl_prod;
            ST_FX_HI, ST_FY_HI: ph_reg <= ph_prod;
            ST_FX_WT:
            begin
                if (div_done)
                begin
                    fx_reg <= (div_quot[95:47] != '0) ? {47{1'b1}} : div_quot[46:0];
                end
            end
            ST_FY_WT:
            begin
                if (div_done)
                begin
                    fy_reg <= (div_quot[95:47] != '0) ? {47{1'b1}} : div_quot[46:0];
                end
            end
            ST_ACC:
            begin
                acc_x_reg <= acc_x_new;
                acc_y_reg <= acc_y_new;
            end
            ST_UPD_LD:
            begin
                mi_reg    <= body_rdata[159:128];
                xi_reg    <= body_rdata[127:96];
                yi_reg    <= body_rdata[95:64];
                vx_reg    <= body_rdata[63:32];
                vy_reg    <= body_rdata[31:0];
                acc_x_reg <= (count_reg == CNT_W'(1)) ? '0 : force_rdata[95:48];
                acc_y_reg <= (count_reg == CNT_W'(1)) ? '0 : force_rdata[47:0];
            end
            ST_AX_WT:
            begin
                if (div_done)
                begin
                    amx_reg <= div_quot[47:0];
                end
            end
            ST_AY_WT:
            begin
                if (div_done)
                begin
                    amy_reg <= div_quot[47:0];
                end
            end
            ST_VMUL:
            begin
                tx_reg <= amx_prod[63:16];
                ty_reg <= amy_prod[63:16];
            end
            ST_VADD:
            begin
                vx_reg <= vx_new;
                vy_reg <= vy_new;
            end
            ST_XMUL:
            begin
                tx_reg <= {16'b0, vpx_prod[47:16]};
                ty_reg <= {16'b0, vpy_prod[47:16]};
            end
            default:
            begin
            end
        endcase
    end

    assign result_valid = out_valid_reg;
    assign status       = out_status_reg;
    assign body_index   = out_idx_reg;
    assign new_pos_x    = out_px_reg;
    assign new_pos_y    = out_py_reg;
    assign new_vel_x    = out_vx_reg;
    assign new_vel_y    = out_vy_reg;
    assign last         = out_last_reg;

endmodule

`default_nettype wire

@@ hw/rtl/nbge_ram.sv @@
// generic single write, single read synchronous ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module nbge_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hw/rtl/nbge_div.sv @@
// restoring divider, one quotient bit per cycle, shared by all divisions of the block
`timescale 1ns / 1ps
`default_nettype none

module nbge_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [nbge_pkg::DIV_W-1:0] dividend,
    input  wire logic [nbge_pkg::DEN_W-1:0] divisor,
    output logic                            done,
    output logic      [nbge_pkg::DIV_W-1:0] quotient
);

    import nbge_pkg::*;

    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     num_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     den_reg;

    logic [DEN_W:0]       trial;
    logic [DEN_W:0]       diff;
    logic                 ge;

    // one trial subtraction
    assign trial = {rem_reg, num_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    // step counter
    always_comb
    begin
        run_next  = run_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
        end
        else if (run_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // dividend shifts out as quotient shifts in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (run_reg)
        begin
            num_reg <= {num_reg[DIV_W-2:0], ge};
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

`default_nettype wire

@@ tb/nbody_gravity_euler_step_tb.sv @@
// self-checking testbench for the n-body gravity euler step block
`timescale 1ns / 1ps

module nbody_gravity_euler_step_tb;
    import nbge_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam logic [1:0] CMD_NONE = 2'd3;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] mass;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [15:0] dt;
    } body_cmd_t;

    typedef struct {
        logic [1:0]  st;
        logic [5:0]  idx;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] vx;
        logic [31:0] vy;
        logic        lst;
    } body_report_t;

    typedef struct {
        body_cmd_t    item;
        bit           typed;
        body_report_t rep;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    logic        start;
    logic        busy;
    logic [1:0]  cmd;
    logic [31:0] body_mass;
    logic [31:0] init_pos_x;
    logic [31:0] init_pos_y;
    logic [31:0] init_vel_x;
    logic [31:0] init_vel_y;
    logic [15:0] step_dt;
    logic        result_valid;
    logic [1:0]  status;
    logic [5:0]  body_index;
    logic [31:0] new_pos_x;
    logic [31:0] new_pos_y;
    logic [31:0] new_vel_x;
    logic [31:0] new_vel_y;
    logic        last;

    nbody_gravity_euler_step uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .start(start), .busy(busy), .cmd(cmd), .body_mass(body_mass),
        .init_pos_x(init_pos_x), .init_pos_y(init_pos_y),
        .init_vel_x(init_vel_x), .init_vel_y(init_vel_y), .step_dt(step_dt),
        .result_valid(result_valid), .status(status), .body_index(body_index),
        .new_pos_x(new_pos_x), .new_pos_y(new_pos_y),
        .new_vel_x(new_vel_x), .new_vel_y(new_vel_y), .last(last)
    );

    // predictor copy of the body store
    logic [31:0] grav;
    int          nbodies;
    logic [31:0] mass_m [MAX_BODIES];
    longint      px_m [MAX_BODIES];
    longint      py_m [MAX_BODIES];
    longint      vx_m [MAX_BODIES];
    longint      vy_m [MAX_BODIES];
    longint      fx_acc [MAX_BODIES];
    longint      fy_acc [MAX_BODIES];

    body_report_t pending_reports [$];
    int errors;
    int cycles;
    int items_sent;
    int steps_sent;
    int reports_seen;
    int idle_pct;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clamp48(longint v);
        if (v > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
        if (v < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
        return v;
    endfunction

    function automatic logic [63:0] absval(longint v);
        return v < 0 ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // floor(a*b/c) on the full product, capped
    function automatic logic [63:0] mul_div_cap(logic [63:0] a, logic [63:0] b,
                                                logic [63:0] c, logic [63:0] cap);
        logic [127:0] prod;
        logic [127:0] q;
        prod = {64'd0, a} * {64'd0, b};
        q = prod / {64'd0, c};
        return (q > {64'd0, cap}) ? cap : q[63:0];
    endfunction

    function automatic longint dt_scale(longint v, logic [15:0] dt);
        longint m;
        m = longint'((absval(v) * {48'd0, dt}) >> 16);
        return v < 0 ? -m : m;
    endfunction

    function automatic body_report_t mk_report(logic [1:0] st, int idx, longint px,
                                               longint py, longint vx, longint vy,
                                               logic lst);
        body_report_t r;
        r.st = st;
        r.idx = idx[5:0];
        r.px = px[31:0];
        r.py = py[31:0];
        r.vx = vx[31:0];
        r.vy = vy[31:0];
        r.lst = lst;
        return r;
    endfunction

    // attraction between bodies i<j, accumulated both ways
    task automatic pair_attract(int i, int j);
        longint dx, dy, fx, fy;
        logic [63:0] ax, ay, s, d, q, f;
        dx = px_m[j] - px_m[i];
        dy = py_m[j] - py_m[i];
        ax = absval(dx);
        ay = absval(dy);
        s = ((ax * ax) >> 2) + ((ay * ay) >> 2);
        d = 2 * int_sqrt(s) + SOFTENING_LSB;
        q = mul_div_cap({32'd0, grav}, {32'd0, mass_m[i]} * {32'd0, mass_m[j]}, d,
                        64'h7FFF_FFFF_FFFF_FFFF);
        f = mul_div_cap(q, 64'd1 << 32, d, 64'h7FFF_FFFF_FFFF);
        fx = longint'(mul_div_cap(f, ax, d, 64'h7FFF_FFFF_FFFF));
        fy = longint'(mul_div_cap(f, ay, d, 64'h7FFF_FFFF_FFFF));
        if (dx < 0) fx = -fx;
        if (dy < 0) fy = -fy;
        fx_acc[i] = clamp48(fx_acc[i] + fx);
        fy_acc[i] = clamp48(fy_acc[i] + fy);
        fx_acc[j] = clamp48(fx_acc[j] - fx);
        fy_acc[j] = clamp48(fy_acc[j] - fy);
    endtask

    // work out the reports caused by one accepted transaction
    task automatic predict_reports(body_cmd_t it, ref body_report_t reps [$]);
        longint axc, ayc;
        logic [63:0] m;
        reps.delete();
        case (it.op)
            CMD_ADD:
            begin
                if (nbodies >= MAX_BODIES)
                begin
                    reps.insert(reps.size(), mk_report(STAT_FULL, 0, 0, 0, 0, 0, 1'b1));
                end
                else
                begin
                    mass_m[nbodies] = it.mass;
                    px_m[nbodies] = longint'($signed(it.px));
                    py_m[nbodies] = longint'($signed(it.py));
                    vx_m[nbodies] = longint'($signed(it.vx));
                    vy_m[nbodies] = longint'($signed(it.vy));
                    reps.insert(reps.size(), mk_report(STAT_OK, nbodies, px_m[nbodies],
                                                       py_m[nbodies], vx_m[nbodies],
                                                       vy_m[nbodies], 1'b1));
                    nbodies++;
                end
            end
            CMD_CLEAR:
            begin
                nbodies = 0;
                reps.insert(reps.size(), mk_report(STAT_OK, 0, 0, 0, 0, 0, 1'b1));
            end
            CMD_STEP:
            begin
                if (nbodies == 0)
                begin
                    reps.insert(reps.size(), mk_report(STAT_EMPTY, 0, 0, 0, 0, 0, 1'b1));
                end
                else
                begin
                    for (int i = 0; i < nbodies; i++)
                    begin
                        fx_acc[i] = 0;
                        fy_acc[i] = 0;
                    end
                    for (int i = 0; i < nbodies; i++)
                        for (int j = i + 1; j < nbodies; j++)
                            pair_attract(i, j);
                    for (int i = 0; i < nbodies; i++)
                    begin
                        // zero mass divides as one
                        m = (mass_m[i] != 0) ? {32'd0, mass_m[i]} : 64'd1;
                        axc = longint'(absval(fx_acc[i]) / m);
                        ayc = longint'(absval(fy_acc[i]) / m);
                        if (fx_acc[i] < 0) axc = -axc;
                        if (fy_acc[i] < 0) ayc = -ayc;
                        vx_m[i] = clamp32(vx_m[i] + dt_scale(axc, it.dt));
                        vy_m[i] = clamp32(vy_m[i] + dt_scale(ayc, it.dt));
                        px_m[i] = clamp32(px_m[i] + dt_scale(vx_m[i], it.dt));
                        py_m[i] = clamp32(py_m[i] + dt_scale(vy_m[i], it.dt));
                        reps.insert(reps.size(), mk_report(STAT_OK, i, px_m[i], py_m[i],
                                                           vx_m[i], vy_m[i],
                                                           (i + 1 == nbodies)));
                    end
                end
            end
            default:
            begin
                // unused command: no report
            end
        endcase
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL nbody_gravity_euler_step");
            $finish;
        end
    end

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // compare each report against the oldest expectation
    always @(posedge clk)
    begin
        body_report_t e;
        if (rst_n && result_valid)
        begin
            reports_seen++;
            if (pending_reports.size() == 0)
            begin
                $error("report with no transaction pending, index %0d", body_index);
                errors++;
            end
            else
            begin
                e = pending_reports.pop_front();
                check_field("status", 32'(e.st), 32'(status));
                check_field("body_index", 32'(e.idx), 32'(body_index));
                check_field("new_pos_x", e.px, new_pos_x);
                check_field("new_pos_y", e.py, new_pos_y);
                check_field("new_vel_x", e.vx, new_vel_x);
                check_field("new_vel_y", e.vy, new_vel_y);
                check_field("last", 32'(e.lst), 32'(last));
            end
        end
    end

    // drive one transaction and wait until it is taken
    task automatic send_cmd(body_cmd_t it, bit typed, body_report_t rep);
        body_report_t reps [$];
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        cmd        <= it.op;
        body_mass  <= it.mass;
        init_pos_x <= it.px;
        init_pos_y <= it.py;
        init_vel_x <= it.vx;
        init_vel_y <= it.vy;
        step_dt    <= it.dt;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict_reports(it, reps);
        if (typed) reps = '{rep};
        foreach (reps[k]) pending_reports.insert(pending_reports.size(), reps[k]);
        items_sent++;
        if (it.op == CMD_STEP) steps_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0 || busy) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_gravity(logic [31:0] g);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= g;
        @(posedge clk);
        cfg_we    <= 1'b0;
        grav = g;
    endtask

    function automatic body_cmd_t mk_cmd(logic [1:0] op, logic [31:0] m, logic [31:0] px,
                                         logic [31:0] py, logic [31:0] vx,
                                         logic [31:0] vy, logic [15:0] dt);
        body_cmd_t c;
        c.op = op;
        c.mass = m;
        c.px = px;
        c.py = py;
        c.vx = vx;
        c.vy = vy;
        c.dt = dt;
        return c;
    endfunction

    function automatic body_cmd_t rand_add(bit near);
        body_cmd_t c;
        c = mk_cmd(CMD_ADD, $urandom, $urandom, $urandom, $urandom, $urandom,
                   16'($urandom));
        if (near)
        begin
            // bodies within a few units so the forces stay moderate
            c.mass = $urandom_range(1, 100000);
            c.px = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
            c.py = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
            c.vx = $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
            c.vy = $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
        end
        return c;
    endfunction

    function automatic body_report_t zero_rep(logic [1:0] st);
        return mk_report(st, 0, 0, 0, 0, 0, 1'b1);
    endfunction

    initial
    begin
        dir_row_t dir_tab [$];
        dir_row_t row;
        body_cmd_t c;
        body_report_t none_rep;
        int nadd;
        int nstep;

        errors = 0;
        cycles = 0;
        items_sent = 0;
        steps_sent = 0;
        reports_seen = 0;
        idle_pct = 25;
        grav = GRAV_RESET;
        nbodies = 0;
        none_rep = zero_rep(STAT_OK);
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        start = 1'b0;
        cmd = CMD_NONE;
        body_mass = '0;
        init_pos_x = '0;
        init_pos_y = '0;
        init_vel_x = '0;
        init_vel_y = '0;
        step_dt = '0;

        // directed table
        dir_tab.insert(dir_tab.size(), '{mk_cmd(CMD_STEP, 0, 0, 0, 0, 0, 16'hFFFF), 1'b1,
                                         zero_rep(STAT_EMPTY)});
        dir_tab.insert(dir_tab.size(), '{mk_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0), 1'b1,
                                         zero_rep(STAT_OK)});
        dir_tab.insert(dir_tab.size(), '{mk_cmd(CMD_ADD, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                                32'h8000_0000, 32'h7FFF_FFFF,
                                                32'h8000_0000, 0), 1'b1,
                                         '{STAT_OK, 6'd0, 32'h7FFF_FFFF, 32'h8000_0000,
                                           32'h7FFF_FFFF, 32'h8000_0000, 1'b1}});
        dir_tab.insert(dir_tab.size(), '{mk_cmd(CMD_ADD, 32'd1, 32'h8000_0000,
                                                32'h7FFF_FFFF, 32'h8000_0000,
                                                32'h7FFF_FFFF, 0), 1'b1,
                                         '{STAT_OK, 6'd1, 32'h8000_0000, 32'h7FFF_FFFF,
                                           32'h8000_0000, 32'h7FFF_FFFF, 1'b1}});
        dir_tab.insert(dir_tab.size(), '{mk_cmd(CMD_STEP, 0, 0, 0, 0, 0, 16'hFFFF), 1'b0,
                                         none_rep});
        dir_tab.insert(dir_tab.size(), '{mk_cmd(CMD_STEP, 0, 0, 0, 0, 0, 16'h0000), 1'b0,
                                         none_rep});
        dir_tab.insert(dir_tab.size(), '{mk_cmd(CMD_NONE, 32'hFFFF_FFFF, 0, 0, 0, 0,
                                                16'hFFFF), 1'b0, none_rep});
        dir_tab.insert(dir_tab.size(), '{mk_cmd(CMD_ADD, 32'd0, 0, 0, 0, 0, 0), 1'b0,
                                         none_rep});
        dir_tab.insert(dir_tab.size(), '{mk_cmd(CMD_ADD, 32'd1000, 32'h0001_0000,
                                                32'hFFFF_0000, 32'h0000_8000, 0, 0),
                                         1'b0, none_rep});
        dir_tab.insert(dir_tab.size(), '{mk_cmd(CMD_STEP, 0, 0, 0, 0, 0, 16'h8000), 1'b0,
                                         none_rep});
        // a body added at the start position of the 1000-mass body
        dir_tab.insert(dir_tab.size(), '{mk_cmd(CMD_ADD, 32'd5000, 32'h0001_0000,
                                                32'hFFFF_0000, 0, 0, 0), 1'b0, none_rep});
        dir_tab.insert(dir_tab.size(), '{mk_cmd(CMD_STEP, 0, 0, 0, 0, 0, 16'hFFFF), 1'b0,
                                         none_rep});
        dir_tab.insert(dir_tab.size(), '{mk_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0), 1'b1,
                                         zero_rep(STAT_OK)});
        dir_tab.insert(dir_tab.size(), '{mk_cmd(CMD_STEP, 0, 0, 0, 0, 0, 16'h1234), 1'b1,
                                         zero_rep(STAT_EMPTY)});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[k])
        begin
            row = dir_tab[k];
            send_cmd(row.item, row.typed, row.rep);
        end

        // fill the store to the top at maximum gravity, then one add too many
        write_gravity(32'hFFFF_FFFF);
        for (int k = 0; k < MAX_BODIES; k++) send_cmd(rand_add(1'b0), 1'b0, none_rep);
        send_cmd(rand_add(1'b0), 1'b1, zero_rep(STAT_FULL));
        send_cmd(mk_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0), 1'b1, zero_rep(STAT_OK));
        for (int k = 0; k < 3; k++) send_cmd(rand_add(1'b1), 1'b0, none_rep);
        send_cmd(mk_cmd(CMD_STEP, 0, 0, 0, 0, 0, 16'hFFFF), 1'b0, none_rep);

        // random phases: well-formed build-and-step sequences with some noise
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0: write_gravity(32'd0);
                1: write_gravity($urandom);
                default: write_gravity($urandom_range(32'h0000_1000, 32'h0010_0000));
            endcase
            idle_pct = (ph == 0) ? 25 : (ph == 1) ? 76 : 0;
            for (int sq = 0; sq < 3; sq++)
            begin
                send_cmd(mk_cmd(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom,
                                $urandom, 16'($urandom)), 1'b0, none_rep);
                nadd = $urandom_range(1, 6);
                for (int k = 0; k < nadd; k++)
                    send_cmd(rand_add($urandom_range(3) != 0), 1'b0, none_rep);
                nstep = $urandom_range(1, 2);
                for (int k = 0; k < nstep; k++)
                begin
                    c = mk_cmd(CMD_STEP, $urandom, $urandom, $urandom, $urandom,
                               $urandom, 16'($urandom));
                    send_cmd(c, 1'b0, none_rep);
                end
                if ($urandom_range(3) == 0)
                    send_cmd(mk_cmd(CMD_NONE, $urandom, $urandom, $urandom, $urandom,
                                    $urandom, 16'($urandom)), 1'b0, none_rep);
            end
        end

        drain();
        repeat (20) @(posedge clk);
        $display("covered %0d transactions (%0d steps), %0d reports checked",
                 items_sent, steps_sent, reports_seen);
        $display("gravity at zero, maximum, reset and random values; store filled to full");
        if (errors == 0 && pending_reports.size() == 0)
        begin
            $display("PASS nbody_gravity_euler_step");
        end
        else
        begin
            $display("FAIL nbody_gravity_euler_step");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/nbge_pkg.sv
hw/rtl/nbge_ram.sv
hw/rtl/nbge_div.sv
hw/rtl/nbody_gravity_euler_step.sv
tb/nbody_gravity_euler_step_tb.sv
